FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while the reset is high.
`define CHK_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rlurs_pkg.sv
// Shared types and constants of the run-length undo ring stack.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rlurs_pkg;

   localparam int CODE_W  = 31;
   localparam int ENTRY_W = 32;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic CSR_MARK  = 1'b0;
   localparam logic CSR_CLEAR = 1'b1;

   localparam logic [CODE_W-1:0]         MARK_RESET = 31'd1400000000;
   localparam logic signed [ENTRY_W-1:0] RUN_LIMIT  = -32'sd1000000000;
   localparam logic signed [ENTRY_W-1:0] RUN_FIRST  = -32'sd2;

   typedef enum logic [1:0] {
      RD_BELOW1,
      RD_BELOW2,
      RD_BOTTOM,
      RD_BOTTOM_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_CODE_AT_TOP,
      WR_RUN_AT_TOP,
      WR_DEC_BELOW1,
      WR_INC_BELOW1
   } wr_sel_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cap_v1;
      logic       top_inc;
      logic       top_to_below1;
      logic       bottom_inc;
      logic       idx_clear;
      logic       res_code;
      logic       res_empty;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       top_eq_bottom;
      logic       push_guard;
      logic       below1_eq_bottom;
      logic       rd_neg;
      logic       rd_eq_code;
      logic       rd_ge_mark;
      logic       code_ge_mark;
      logic       v1_gt_limit;
      logic       v1_is_first;
      logic       near_bottom;
      logic       next_bottom_eq_top;
      logic       out_free;
   } status_type;

endpackage

FILE: hdl/rlurs_ctrl.sv
// Controller state machine of the run-length undo ring stack.
// Depends on rlurs_pkg; drives the datapath through cmd_type and reads status_type.
`timescale 1ns / 1ps

module rlurs_ctrl
   import rlurs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ1,
      S_READ2,
      S_EVAL,
      S_PROBE,
      S_WALK,
      S_WCHK,
      S_FCHK,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = S_READ1;
            end
         end
         S_READ1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_BELOW1;
            case (status.op)
               OP_PUSH: begin
                  if (!status.push_guard) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_CODE_AT_TOP;
                     cmd.top_inc = 1'b1;
                     state_in    = S_PROBE;
                  end else begin
                     state_in = S_READ2;
                  end
               end
               OP_POP, OP_PEEK: begin
                  if (status.top_eq_bottom) begin
                     cmd.res_empty = 1'b1;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_READ2;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_READ2: begin
            cmd.cap_v1 = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_BELOW2;
            if (status.op == OP_PUSH) begin
               if (status.rd_neg) begin
                  state_in = S_EVAL;
               end else if (status.rd_eq_code) begin
                  if (status.code_ge_mark) begin
                     state_in = S_OUT;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_RUN_AT_TOP;
                     cmd.top_inc = 1'b1;
                     state_in    = S_PROBE;
                  end
               end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_sel  = WR_CODE_AT_TOP;
                  cmd.top_inc = 1'b1;
                  state_in    = S_PROBE;
               end
            end else begin
               if (!status.rd_neg) begin
                  cmd.res_code      = 1'b1;
                  cmd.top_to_below1 = (status.op == OP_POP);
                  state_in          = S_OUT;
               end else if (status.below1_eq_bottom) begin
                  cmd.res_empty = 1'b1;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (status.op == OP_PUSH) begin
               if (status.rd_eq_code && status.v1_gt_limit) begin
                  if (!status.code_ge_mark) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_DEC_BELOW1;
                  end
                  state_in = S_OUT;
               end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_sel  = WR_CODE_AT_TOP;
                  cmd.top_inc = 1'b1;
                  state_in    = S_PROBE;
               end
            end else begin
               cmd.res_code = 1'b1;
               if (status.op == OP_POP) begin
                  if (status.v1_is_first) begin
                     cmd.top_to_below1 = 1'b1;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_INC_BELOW1;
                  end
               end
               state_in = S_OUT;
            end
         end
         S_PROBE: begin
            if (status.near_bottom) begin
               state_in = S_WALK;
            end else if (status.top_eq_bottom) begin
               state_in = S_OUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BOTTOM;
               state_in   = S_FCHK;
            end
         end
         S_WALK: begin
            cmd.bottom_inc = 1'b1;
            if (status.next_bottom_eq_top) begin
               state_in = S_OUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BOTTOM_NEXT;
               state_in   = S_WCHK;
            end
         end
         S_WCHK: begin
            state_in = status.rd_ge_mark ? S_OUT : S_WALK;
         end
         S_FCHK: begin
            cmd.idx_clear = !status.rd_ge_mark;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/rlurs_dp.sv
// Datapath of the run-length undo ring stack: entry memory, ring indexes,
// configuration registers and the result register. Depends on rlurs_pkg.
`timescale 1ns / 1ps

module rlurs_dp
   import rlurs_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_op,
   input  logic [CODE_W-1:0]   req_code,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CODE_W-1:0]   csr_wdata,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [CODE_W-1:0]   rsp_code,
   output logic                rsp_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] i, input logic [1:0] k);
      logic [AW:0] s;
      s = {1'b0, i} + {{(AW - 1){1'b0}}, k};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] i);
      return (i == '0) ? LAST : i - 1'b1;
   endfunction

   logic signed [ENTRY_W-1:0] entry_store_ff [DEPTH];
   logic signed [ENTRY_W-1:0] rd_data_ff;
   logic signed [ENTRY_W-1:0] v1_ff;
   logic [1:0]                op_ff;
   logic [CODE_W-1:0]         code_ff;
   logic [CODE_W-1:0]         mark_ff;
   logic                      clear_ff;
   logic [AW-1:0]             top_ff;
   logic [AW-1:0]             top_in;
   logic [AW-1:0]             bottom_ff;
   logic [AW-1:0]             bottom_in;
   logic [CODE_W-1:0]         res_code_ff;
   logic                      res_empty_ff;
   logic                      rsp_valid_ff;
   logic [CODE_W-1:0]         rsp_code_ff;
   logic                      rsp_empty_ff;

   logic [AW-1:0]             below1;
   logic [AW-1:0]             below2;
   logic [AW-1:0]             probe0;
   logic [AW-1:0]             probe1;
   logic [AW-1:0]             bottom_next;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic signed [ENTRY_W-1:0] wr_data;

   assign below1      = ring_dec(top_ff);
   assign below2      = ring_dec(below1);
   assign probe0      = ring_add(top_ff, 2'd2);
   assign probe1      = ring_add(top_ff, 2'd3);
   assign bottom_next = ring_add(bottom_ff, 2'd1);

   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW1:      rd_addr = below1;
         RD_BELOW2:      rd_addr = below2;
         RD_BOTTOM:      rd_addr = bottom_ff;
         RD_BOTTOM_NEXT: rd_addr = bottom_next;
         default:        rd_addr = bottom_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_CODE_AT_TOP: begin
            wr_addr = top_ff;
            wr_data = {1'b0, code_ff};
         end
         WR_RUN_AT_TOP: begin
            wr_addr = top_ff;
            wr_data = RUN_FIRST;
         end
         WR_DEC_BELOW1: begin
            wr_addr = below1;
            wr_data = v1_ff - 32'sd1;
         end
         WR_INC_BELOW1: begin
            wr_addr = below1;
            wr_data = v1_ff + 32'sd1;
         end
         default: begin
            wr_addr = top_ff;
            wr_data = {1'b0, code_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

   always_comb begin
      top_in    = top_ff;
      bottom_in = bottom_ff;
      if (cmd.accept && req_op == OP_PUSH && clear_ff) begin
         top_in    = '0;
         bottom_in = '0;
      end
      if (cmd.top_inc) begin
         top_in = ring_add(top_ff, 2'd1);
      end
      if (cmd.top_to_below1) begin
         top_in = below1;
      end
      if (cmd.bottom_inc) begin
         bottom_in = bottom_next;
      end
      if (cmd.idx_clear) begin
         top_in    = '0;
         bottom_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         bottom_ff    <= '0;
         mark_ff      <= MARK_RESET;
         clear_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MARK:  mark_ff  <= csr_wdata;
               CSR_CLEAR: clear_ff <= csr_wdata[0];
               default:   mark_ff  <= mark_ff;
            endcase
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_op;
         code_ff      <= req_code;
         res_code_ff  <= '0;
         res_empty_ff <= 1'b0;
      end else begin
         if (cmd.res_code) begin
            res_code_ff <= rd_data_ff[CODE_W-1:0];
         end
         if (cmd.res_empty) begin
            res_empty_ff <= 1'b1;
         end
      end
      if (cmd.cap_v1) begin
         v1_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_code_ff  <= res_code_ff;
         rsp_empty_ff <= res_empty_ff;
      end
   end

   always_comb begin
      status.op                 = op_ff;
      status.top_eq_bottom      = (top_ff == bottom_ff);
      status.push_guard         = (bottom_ff != top_ff) && (below1 != bottom_ff)
                                  && (below2 != bottom_ff);
      status.below1_eq_bottom   = (below1 == bottom_ff);
      status.rd_neg             = rd_data_ff[ENTRY_W-1];
      status.rd_eq_code         = (rd_data_ff == {1'b0, code_ff});
      status.rd_ge_mark         = !rd_data_ff[ENTRY_W-1]
                                  && (rd_data_ff[CODE_W-1:0] >= mark_ff);
      status.code_ge_mark       = (code_ff >= mark_ff);
      status.v1_gt_limit        = (v1_ff > RUN_LIMIT);
      status.v1_is_first        = (v1_ff == RUN_FIRST);
      status.near_bottom        = (probe0 == bottom_ff) || (probe1 == bottom_ff);
      status.next_bottom_eq_top = (bottom_next == top_ff);
      status.out_free           = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_code   = rsp_code_ff;
   assign rsp_empty  = rsp_empty_ff;

endmodule

FILE: hdl/run_length_undo_ring_stack.sv
// Top level of the run-length undo ring stack: controller plus datapath.
// Depends on rlurs_pkg, rlurs_ctrl and rlurs_dp.
//
//   Channel  Direction  Handshake              Word contents
//   req      in         req_tvalid/req_tready  tdata: action_code; tuser: operation
//   rsp      out        rsp_tvalid/rsp_tready  tdata: code_out; tuser: empty_res
//   csr      in         csr_we                 csr_index selects, csr_wdata holds value
//
// One item is handled at a time; each word gives exactly one response word.
// A pop, peek or push runs through the controller states one memory read at a time, and a push
// that walks the bottom index forward reads the entries it walks one after another.
// The response sits in an output register, so a stalled rsp side holds only
// the final step; reset is synchronous, holds req_tready low and needs no clearing pass.
`timescale 1ns / 1ps

module run_length_undo_ring_stack
   import rlurs_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] action_code, [31] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] code_out, [31] zero
   output logic        rsp_tuser,   // [0] empty_res
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   cmd_type           cmd;
   status_type        status;
   logic [CODE_W-1:0] rsp_code;

   rlurs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rlurs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_code   (req_tdata[CODE_W-1:0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_code   (rsp_code),
      .rsp_empty  (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_code};

endmodule

FILE: hdl/rlurs_checker.sv
// Port-level checker for the run-length undo ring stack and its bind.
// Depends on assert_macros.svh; attaches to run_length_undo_ring_stack.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlurs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   `CHK_ASSERT_NR(a_reset_no_rsp, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `CHK_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled response word changed")
   `CHK_ASSERT(a_empty_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0,
      "empty response carries a nonzero code")
   `CHK_ASSERT(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready,
      "request taken while a word is in work")

endmodule

bind run_length_undo_ring_stack rlurs_checker u_rlurs_checker (.*);

FILE: sim/run_length_undo_ring_stack_tb.sv
// Self-checking testbench for run_length_undo_ring_stack: a directed table, then random
// push/pop/peek traffic under several register settings, checked against a local predictor.
// Depends on rlurs_pkg and the run_length_undo_ring_stack RTL.
`timescale 1ns / 1ps

module run_length_undo_ring_stack_tb;
   import rlurs_pkg::*;

   localparam int RING_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 30;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [CODE_W-1:0] CODE_MAX = 31'h7FFFFFFF;

   typedef logic [9:0] slot_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              empty;
   } reply_type;

   typedef struct {
      logic [1:0]        op;
      logic [CODE_W-1:0] code;
      bit                typed;
      reply_type         reply;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [30:0] csr_wdata = '0;

   int                undo_mem [RING_DEPTH];
   slot_type          top_slot;
   slot_type          base_slot;
   logic [CODE_W-1:0] mark_reg;
   logic              clear_reg;
   logic [CODE_W-1:0] last_code;

   reply_type      reply_queue [$];
   script_row_type script [$];
   int             fail_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 14;
   int             recv_idle_pct = 55;
   int             hold_requests = 0;
   int             hold_seen = 0;
   int             hold_left = 0;

   run_length_undo_ring_stack uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic bit is_mark(int value);
      return value >= int'({1'b0, mark_reg});
   endfunction

   function automatic bit mark_above_base();
      slot_type s;
      s = slot_type'(base_slot + 1);
      while (s != top_slot) begin
         if (is_mark(undo_mem[s])) return 1'b1;
         s = slot_type'(s + 1);
      end
      return 1'b0;
   endfunction

   function automatic reply_type stack_apply(logic [1:0] op, logic [CODE_W-1:0] code);
      reply_type r;
      slot_type  sp, b1, b2, probe, below;
      int        c, v, n;
      bit        keep, done;
      r = '0;
      c = int'({1'b0, code});
      keep = 1'b1;
      done = 1'b0;
      n = 0;
      case (op)
         OP_PUSH: begin
            if (clear_reg) begin
               base_slot = '0;
               top_slot = '0;
            end
            sp = top_slot;
            b1 = slot_type'(sp - 1);
            b2 = slot_type'(sp - 2);
            if (base_slot != sp && b1 != base_slot && b2 != base_slot) begin
               if (undo_mem[b1] < 0) begin
                  if (undo_mem[b2] == c && undo_mem[b1] > RUN_LIMIT) begin
                     if (!is_mark(c)) undo_mem[b1] = undo_mem[b1] - 1;
                     done = 1'b1;
                  end
               end else if (undo_mem[b1] == c) begin
                  if (is_mark(c)) begin
                     done = 1'b1;
                  end else begin
                     undo_mem[sp] = RUN_FIRST;
                     keep = 1'b0;
                  end
               end
            end
            if (!done) begin
               if (keep) undo_mem[sp] = c;
               top_slot = slot_type'(sp + 1);
               probe = slot_type'(top_slot + 2);
               if (probe == base_slot || slot_type'(probe + 1) == base_slot) begin
                  // Walk the bottom forward to the next group mark or to the top slot.
                  while (n < RING_DEPTH) begin
                     base_slot = slot_type'(base_slot + 1);
                     n++;
                     if (is_mark(undo_mem[base_slot]) || base_slot == top_slot) n = RING_DEPTH;
                  end
               end
               if (top_slot != base_slot && !is_mark(undo_mem[base_slot])) begin
                  base_slot = '0;
                  top_slot = '0;
               end
            end
         end
         OP_POP, OP_PEEK: begin
            if (top_slot == base_slot) begin
               r.empty = 1'b1;
            end else begin
               below = slot_type'(top_slot - 1);
               v = undo_mem[below];
               if (v >= 0) begin
                  r.code = v[CODE_W-1:0];
                  if (op == OP_POP) top_slot = below;
               end else if (below == base_slot) begin
                  r.empty = 1'b1;
               end else begin
                  r.code = undo_mem[slot_type'(below - 1)][CODE_W-1:0];
                  if (op == OP_POP) begin
                     if (undo_mem[below] == RUN_FIRST) top_slot = below;
                     else undo_mem[below] = undo_mem[below] + 1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll < 4) return last_code;
      if (roll < 7) return CODE_W'($urandom_range(0, 3));
      if (roll < 9) return mark_reg;
      if (roll < 10) return mark_reg - 1'b1;
      if (roll < 11) return CODE_MAX;
      return CODE_W'($urandom);
   endfunction

   function automatic logic [CODE_W-1:0] fill_code();
      if ($urandom_range(0, 11) == 0) return CODE_W'($urandom_range(mark_reg, CODE_MAX));
      if ($urandom_range(0, 19) == 0) return last_code;
      return CODE_W'($urandom_range(0, mark_reg - 1'b1));
   endfunction

   // Near a full ring the bottom walk must find a mark before it reaches the top slot.
   function automatic logic [CODE_W-1:0] guard_code(logic [CODE_W-1:0] code);
      if (!clear_reg && slot_type'(top_slot - base_slot) >= RING_DEPTH - 8 && !mark_above_base())
         return CODE_W'($urandom_range(mark_reg, CODE_MAX));
      return code;
   endfunction

   function automatic void add_row(logic [1:0] op, logic [CODE_W-1:0] code, bit typed,
                                   logic [CODE_W-1:0] exp_code, logic exp_empty);
      script_row_type row;
      row.op = op;
      row.code = code;
      row.typed = typed;
      row.reply.code = exp_code;
      row.reply.empty = exp_empty;
      script.push_back(row);
   endfunction

   task automatic send_word(logic [1:0] op, logic [CODE_W-1:0] code, bit typed,
                            reply_type typed_reply);
      reply_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, code};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      predicted = stack_apply(op, code);
      reply_queue.push_back(typed ? typed_reply : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (reply_queue.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic index, logic [30:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_MARK) mark_reg = value;
      else clear_reg = value[0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(int count, bit fill, int pause_at);
      int                sent;
      int                roll;
      logic [1:0]        op;
      logic [CODE_W-1:0] code;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (fill) op = (roll < 3) ? OP_PEEK : OP_PUSH;
         else op = (roll < 55) ? OP_PUSH : (roll < 80) ? OP_POP :
                   (roll < 95) ? OP_PEEK : OP_NONE;
         code = CODE_W'($urandom);
         if (op == OP_PUSH) begin
            code = guard_code(fill ? fill_code() : pick_code());
            last_code = code;
         end
         send_word(op, code, 1'b0, '0);
         if (op != OP_NONE) begin
            sent++;
            if (sent == pause_at) wait_drain();
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reply_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected word: tdata %h tuser %b", rsp_tdata, rsp_tuser);
         end else begin
            want = reply_queue.pop_front();
            if (rsp_tdata !== {1'b0, want.code} || rsp_tuser !== want.empty) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("word mismatch: expected code %h empty %b, got tdata %h tuser %b",
                           want.code, want.empty, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      foreach (undo_mem[i]) undo_mem[i] = 0;
      top_slot = '0;
      base_slot = '0;
      mark_reg = MARK_RESET;
      clear_reg = 1'b0;
      last_code = '0;

      add_row(OP_POP,  '0, 1'b1, '0, 1'b1);
      add_row(OP_PEEK, '0, 1'b1, '0, 1'b1);
      add_row(OP_NONE, '0, 1'b1, '0, 1'b0);
      add_row(OP_PUSH, 31'd5, 1'b1, '0, 1'b0);
      add_row(OP_PEEK, '0, 1'b1, '0, 1'b1);
      add_row(OP_PUSH, CODE_MAX, 1'b1, '0, 1'b0);
      add_row(OP_PUSH, CODE_MAX, 1'b1, '0, 1'b0);
      repeat (4) add_row(OP_PUSH, '0, 1'b1, '0, 1'b0);
      add_row(OP_PEEK, '0, 1'b0, '0, 1'b0);
      repeat (6) add_row(OP_POP, '0, 1'b0, '0, 1'b0);
      add_row(OP_PUSH, MARK_RESET, 1'b1, '0, 1'b0);
      add_row(OP_PUSH, MARK_RESET - 1'b1, 1'b1, '0, 1'b0);
      add_row(OP_PUSH, MARK_RESET - 1'b1, 1'b1, '0, 1'b0);
      add_row(OP_PUSH, MARK_RESET, 1'b1, '0, 1'b0);
      add_row(OP_PUSH, MARK_RESET, 1'b1, '0, 1'b0);
      add_row(OP_NONE, CODE_MAX, 1'b1, '0, 1'b0);
      add_row(OP_PEEK, '0, 1'b0, '0, 1'b0);
      add_row(OP_POP,  '0, 1'b0, '0, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_word(script[i].op, script[i].code, script[i].typed, script[i].reply);
      end

      wait_drain();
      write_csr(CSR_MARK, 31'h40000000);
      write_csr(CSR_CLEAR, 31'd0);
      run_random(350, 1'b0, 175);

      wait_drain();
      send_idle_pct = 55;
      recv_idle_pct = 14;
      write_csr(CSR_MARK, 31'd1);
      write_csr(CSR_CLEAR, 31'd1);
      run_random(120, 1'b0, 0);

      wait_drain();
      write_csr(CSR_MARK, CODE_MAX);
      write_csr(CSR_CLEAR, 31'd0);
      run_random(230, 1'b0, 0);

      wait_drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_MARK, CODE_W'($urandom_range(1000000000, 1500000000)));
      hold_requests++;
      run_random(1230, 1'b1, 0);

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && reply_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
